// ===== sv/shp_pkg.sv =====
// Shared types and constants for the 3x3 sharpen filter.
// No dependencies; used by the top level and the port checker.
package shp_pkg;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned WIDTH_W  = 11;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned CHAN_W   = 3;
  localparam int unsigned ACC_W    = 12;  // holds -1020..1275 as two's complement

  localparam int unsigned MAX_HEIGHT = 4096;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH   = 2'd0,
    REG_IMAGE_HEIGHT  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_t;

  localparam logic [WIDTH_W-1:0]  IMAGE_WIDTH_RST   = 11'd640;
  localparam logic [HEIGHT_W-1:0] IMAGE_HEIGHT_RST  = 13'd480;
  localparam logic [CHAN_W-1:0]   CHANNEL_COUNT_RST = 3'd1;

endpackage

// ===== sv/shp_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies; used for both line stores of the sharpen filter.
module shp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // read-before-write on an address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem[raddr_a];
      rdata_b_r <= mem[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ===== sv/sharpen_3x3_laplacian_filter_top.sv =====
// 3x3 sharpen filter on a raster of channel-interleaved 8-bit samples.
// Depends on shp_pkg and shp_ram.
//
// Takes one sample per clock and gives one result per clock while nothing
// stalls: a transfer enters an input stage, the two line-store RAMs are read
// on the way into the second stage, and the result register is loaded from
// the second stage. Results for row r-1
// come out while row r goes in; row 0 gives
// none, and one flush row of image_width*channel_count items (in_flush
// high) after the frame drains the bottom row. Border samples give 0 and
// out_frame_end marks the last result of the frame. The line stores are
// MAX_WIDTH*MAX_CHANNELS bytes each, need no clearing after reset, and
// must only be reprogrammed between frames.
module sharpen_3x3_laplacian_filter_top #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [shp_pkg::PADDR_W-1:0]  paddr,
  input  logic [shp_pkg::PDATA_W-1:0]  pwdata,
  output logic [shp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // sample stream in
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [shp_pkg::PIX_W-1:0]    in_sample,
  input  logic                         in_flush,
  // result stream out
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [shp_pkg::PIX_W-1:0]    out_sharpened,
  output logic                         out_frame_end
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LW    = $clog2(DEPTH + 1);
  localparam int unsigned WW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CW    = $clog2(MAX_CHANNELS + 1);
  localparam int unsigned HW    = shp_pkg::HEIGHT_W;
  localparam int unsigned PW    = shp_pkg::PIX_W;
  localparam int unsigned XW    = shp_pkg::ACC_W;

  // ---------------------------------------------------------------- config
  logic [shp_pkg::WIDTH_W-1:0]  image_width_r;
  logic [shp_pkg::HEIGHT_W-1:0] image_height_r;
  logic [shp_pkg::CHAN_W-1:0]   channel_count_r;
  logic                         cfg_wr;
  logic [1:0]                   reg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_sel = paddr[shp_pkg::PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= shp_pkg::IMAGE_WIDTH_RST;
      image_height_r  <= shp_pkg::IMAGE_HEIGHT_RST;
      channel_count_r <= shp_pkg::CHANNEL_COUNT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        shp_pkg::REG_IMAGE_WIDTH:   image_width_r   <= pwdata[shp_pkg::WIDTH_W-1:0];
        shp_pkg::REG_IMAGE_HEIGHT:  image_height_r  <= pwdata[shp_pkg::HEIGHT_W-1:0];
        shp_pkg::REG_CHANNEL_COUNT: channel_count_r <= pwdata[shp_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      shp_pkg::REG_IMAGE_WIDTH:   prdata = shp_pkg::PDATA_W'(image_width_r);
      shp_pkg::REG_IMAGE_HEIGHT:  prdata = shp_pkg::PDATA_W'(image_height_r);
      shp_pkg::REG_CHANNEL_COUNT: prdata = shp_pkg::PDATA_W'(channel_count_r);
      default:                    prdata = '0;
    endcase
  end

  // effective frame geometry
  logic [WW-1:0] w_eff;
  logic [CW-1:0] ch_eff;
  logic [HW-1:0] h_eff;
  logic [LW-1:0] row_len;
  logic [LW-1:0] row_len_m1;

  always_comb begin
    if (image_width_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width_r);
    end

    if (channel_count_r == '0) begin
      ch_eff = CW'(1);
    end else if (32'(channel_count_r) > MAX_CHANNELS) begin
      ch_eff = CW'(MAX_CHANNELS);
    end else begin
      ch_eff = CW'(channel_count_r);
    end

    if (image_height_r == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height_r) > shp_pkg::MAX_HEIGHT) begin
      h_eff = HW'(shp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
  end

  assign row_len    = LW'(w_eff) * LW'(ch_eff);
  assign row_len_m1 = row_len - LW'(1);

  // ------------------------------------------------------ position counters
  logic          en_out;
  logic          en_b;
  logic          en_a;
  logic          in_xfer;

  logic [AW-1:0] col_cnt_r;
  logic [HW-1:0] row_cnt_r;
  logic [AW-1:0] col_cnt_nxt;
  logic [HW-1:0] row_cnt_nxt;
  logic [AW-1:0] col_cl;
  logic [HW-1:0] row_cl;
  logic          last_in_row;
  logic          produce;
  logic          interior;
  logic          frame_end;
  logic [PW-1:0] sample_in;

  assign in_xfer = in_valid & ~in_stall;

  always_comb begin
    col_cl      = (LW'(col_cnt_r) > row_len_m1) ? AW'(row_len_m1) : col_cnt_r;
    row_cl      = (row_cnt_r > h_eff) ? h_eff : row_cnt_r;
    last_in_row = (LW'(col_cl) == row_len_m1);
    produce     = (row_cl != '0);
    // output row is row_cl-1: must be neither the first nor the last row, and the column not in the first or last pixel
    interior    = (row_cl >= HW'(2)) && (row_cl < h_eff) &&
                  (LW'(col_cl) >= LW'(ch_eff)) &&
                  ((LW + 1)'(col_cl) + (LW + 1)'(ch_eff) < (LW + 1)'(row_len));
    frame_end   = (row_cl >= h_eff) && last_in_row;
    sample_in   = in_flush ? '0 : in_sample;

    if (last_in_row) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = (row_cl >= h_eff) ? '0 : row_cl + HW'(1);
    end else begin
      col_cnt_nxt = col_cl + AW'(1);
      row_cnt_nxt = row_cl;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (in_xfer) begin
      col_cnt_r <= col_cnt_nxt;
      row_cnt_r <= row_cnt_nxt;
    end
  end

  // ------------------------------------------------------ stage A: input
  logic          a_valid_r;
  logic [AW-1:0] a_col_r;
  logic [AW-1:0] a_left_r;
  logic [AW-1:0] a_right_r;
  logic [PW-1:0] a_sample_r;
  logic          a_produce_r;
  logic          a_interior_r;
  logic          a_frame_end_r;
  logic          b_valid_r;
  logic          out_valid_r;

  // stages move independently so bubbles collapse
  assign en_out   = ~out_valid_r | ~out_stall;
  assign en_b     = ~b_valid_r | en_out;
  assign en_a     = ~a_valid_r | en_b;
  assign in_stall = ~en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en_a) begin
      a_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) begin
      a_col_r       <= col_cl;
      a_left_r      <= col_cl - AW'(ch_eff);
      a_right_r     <= col_cl + AW'(ch_eff);
      a_sample_r    <= sample_in;
      a_produce_r   <= produce;
      a_interior_r  <= interior;
      a_frame_end_r <= frame_end;
    end
  end

  // ------------------------------------------------------ line stores
  // line_one holds the previous row; line_two holds, left of the current
  // column, the previous row again and, from it onwards, the row before.
  logic [PW-1:0] l1_centre;
  logic [PW-1:0] l1_right;
  logic [PW-1:0] l2_left;
  logic [PW-1:0] l2_up;
  logic [AW-1:0] b_col_r;

  shp_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line_one (
    .clk     (clk),
    .we      (a_valid_r & en_b),
    .waddr   (a_col_r),
    .wdata   (a_sample_r),
    .re      (en_b),
    .raddr_a (a_col_r),
    .raddr_b (a_right_r),
    .rdata_a (l1_centre),
    .rdata_b (l1_right)
  );

  shp_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH)
  ) u_line_two (
    .clk     (clk),
    .we      (b_valid_r & en_out),
    .waddr   (b_col_r),
    .wdata   (l1_centre),
    .re      (en_b),
    .raddr_a (a_left_r),
    .raddr_b (a_col_r),
    .rdata_a (l2_left),
    .rdata_b (l2_up)
  );

  // ------------------------------------------------------ stage B: kernel
  logic [PW-1:0] b_sample_r;
  logic          b_produce_r;
  logic          b_interior_r;
  logic          b_frame_end_r;
  logic          fwd_left_r;
  logic          fwd_up_r;
  logic [PW-1:0] fwd_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en_b) begin
      b_valid_r <= a_valid_r;
    end
  end

  // the item leaving B writes line_two in the same cycle the next one reads
  // it; catch that collision and forward the written value
  always_ff @(posedge clk) begin
    if (en_b) begin
      b_col_r       <= a_col_r;
      b_sample_r    <= a_sample_r;
      b_produce_r   <= a_produce_r;
      b_interior_r  <= a_interior_r;
      b_frame_end_r <= a_frame_end_r;
      fwd_left_r    <= b_valid_r && (b_col_r == a_left_r);
      fwd_up_r      <= b_valid_r && (b_col_r == a_col_r);
      fwd_val_r     <= l1_centre;
    end
  end

  logic [PW-1:0] left_px;
  logic [PW-1:0] up_px;
  logic [XW-1:0] five_centre;
  logic [XW-1:0] acc;
  logic [PW-1:0] clamped;

  always_comb begin
    left_px     = fwd_left_r ? fwd_val_r : l2_left;
    up_px       = fwd_up_r ? fwd_val_r : l2_up;
    five_centre = (XW'(l1_centre) << 2) + XW'(l1_centre);
    acc         = five_centre - XW'(left_px) - XW'(l1_right) - XW'(up_px) -
                  XW'(b_sample_r);
    if (acc[XW-1]) begin
      clamped = '0;
    end else if (acc > XW'(255)) begin
      clamped = '1;
    end else begin
      clamped = acc[PW-1:0];
    end
  end

  // ------------------------------------------------------ result register
  logic [PW-1:0] out_sharpened_r;
  logic          out_frame_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= b_valid_r & b_produce_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      out_sharpened_r <= b_interior_r ? clamped : '0;
      out_frame_end_r <= b_frame_end_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sharpened = out_sharpened_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ===== sv/shp_checker.sv =====
// Port-level checks for the sharpen filter, bound to the top level.
// Depends on shp_pkg and sharpen_3x3_laplacian_filter_top.
module shp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [shp_pkg::PIX_W-1:0] out_sharpened,
  input logic                      out_frame_end
);

  // pipeline comes out of reset empty and ready
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // input is only held back by a result that is waiting to be taken
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no blocked result");

  // the last sample of a frame sits on the right border
  a_frame_end_border: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_sharpened == '0)
    else $error("frame end result not zero");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_sharpened) && $stable(out_frame_end))
    else $error("stalled result transfer changed");

endmodule

bind sharpen_3x3_laplacian_filter_top shp_checker u_shp_checker (.*);

// ===== tb/sv/sharpen_3x3_laplacian_filter_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sharpen_3x3_laplacian_filter_top.
// Depends on shp_pkg and the filter RTL; a scoreboard class predicts every
// result from the accepted samples and the programmed frame geometry.
module sharpen_3x3_laplacian_filter_top_test;

  localparam int unsigned LINE_MAX      = 1024;
  localparam int unsigned CHAN_MAX      = 4;
  localparam int unsigned STORE_SIZE    = LINE_MAX * CHAN_MAX;
  localparam int unsigned RANDOM_ITEMS  = 1300;
  localparam int unsigned IDLE_PCT      = 29;
  localparam int unsigned CALM_FROM     = 500;
  localparam int unsigned CALM_TO       = 800;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned REPORT_MAX    = 10;

  // hand-made 4x3 grey frame plus its flush row, in raster order
  localparam logic [16*shp_pkg::PIX_W-1:0] DIR_PIX = {
    8'd10, 8'd20,  8'd255, 8'd30,
    8'd0,  8'd255, 8'd0,   8'd40,
    8'd5,  8'd99,  8'd77,  8'd255,
    8'd0,  8'd200, 8'd255, 8'd0
  };
  localparam logic [15:0] DIR_FLUSH = 16'b0000_0000_0100_1011;

  typedef struct packed {
    logic [shp_pkg::PIX_W-1:0] pix;
    logic                      last;
  } pixel_t;

  // register value as the block reads it: 0 acts as 1, large values saturate
  function automatic int unsigned effective(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  class sharpen_scoreboard;
    logic [shp_pkg::WIDTH_W-1:0]  img_w;
    logic [shp_pkg::HEIGHT_W-1:0] img_h;
    logic [shp_pkg::CHAN_W-1:0]   chans;
    logic [shp_pkg::PIX_W-1:0]    line_one [STORE_SIZE];
    logic [shp_pkg::PIX_W-1:0]    line_two [STORE_SIZE];
    int unsigned                  row_idx;
    int unsigned                  col_idx;
    pixel_t                       due_pixels [$];
    int unsigned                  failures;

    function new();
      img_w = shp_pkg::IMAGE_WIDTH_RST;
      img_h = shp_pkg::IMAGE_HEIGHT_RST;
      chans = shp_pkg::CHANNEL_COUNT_RST;
      foreach (line_one[i]) begin
        line_one[i] = '0;
        line_two[i] = '0;
      end
      row_idx  = 0;
      col_idx  = 0;
      failures = 0;
    endfunction

    function void set_reg(shp_pkg::reg_idx_t idx, logic [shp_pkg::PDATA_W-1:0] v);
      case (idx)
        shp_pkg::REG_IMAGE_WIDTH: begin
          img_w = v[shp_pkg::WIDTH_W-1:0];
        end
        shp_pkg::REG_IMAGE_HEIGHT: begin
          img_h = v[shp_pkg::HEIGHT_W-1:0];
        end
        shp_pkg::REG_CHANNEL_COUNT: begin
          chans = v[shp_pkg::CHAN_W-1:0];
        end
        default: ;
      endcase
    endfunction

    function void take_sample(logic [shp_pkg::PIX_W-1:0] s, logic f);
      int unsigned               w, h, ch, len, c, r, orow;
      int                        acc;
      logic [shp_pkg::PIX_W-1:0] down;
      bit                        row_end;
      pixel_t                    p;
      w    = effective(img_w, LINE_MAX);
      h    = effective(img_h, shp_pkg::MAX_HEIGHT);
      ch   = effective(chans, CHAN_MAX);
      len  = w * ch;
      c    = (col_idx > len - 1) ? len - 1 : col_idx;
      r    = (row_idx > h) ? h : row_idx;
      down = f ? '0 : s;
      row_end = (c == len - 1);
      // row r carries the results of row r-1
      if (r >= 1) begin
        orow  = r - 1;
        p.pix = '0;
        if (orow >= 1 && orow + 1 < h && c >= ch && c + ch < len) begin
          // left neighbour already moved down into line_two this row
          acc = 5 * int'(line_one[c]) - int'(line_one[c + ch]) - int'(line_two[c - ch])
                - int'(line_two[c]) - int'(down);
          if (acc < 0) acc = 0;
          else if (acc > 255) acc = 255;
          p.pix = acc[shp_pkg::PIX_W-1:0];
        end
        p.last = (orow + 1 >= h) && row_end;
        due_pixels.push_back(p);
      end
      line_two[c] = line_one[c];
      line_one[c] = down;
      if (row_end) begin
        col_idx = 0;
        row_idx = (r >= h) ? 0 : r + 1;
      end else begin
        col_idx = c + 1;
        row_idx = r;
      end
    endfunction

    function void check_pixel(logic [shp_pkg::PIX_W-1:0] pix, logic last);
      pixel_t want;
      if (due_pixels.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: unexpected result sharpened=%0d frame_end=%0b", $time, pix, last);
        return;
      end
      want = due_pixels.pop_front();
      if (want.pix !== pix || want.last !== last) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: mismatch: expected sharpened=%0d frame_end=%0b, got %0d/%0b",
                   $time, want.pix, want.last, pix, last);
      end
    endfunction

    function int unsigned pending();
      return due_pixels.size();
    endfunction
  endclass

  logic                         clk     = 1'b0;
  logic                         rst_n   = 1'b0;
  logic                         psel    = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite  = 1'b0;
  logic [shp_pkg::PADDR_W-1:0]  paddr   = '0;
  logic [shp_pkg::PDATA_W-1:0]  pwdata  = '0;
  logic [shp_pkg::PDATA_W-1:0]  prdata;
  logic                         pready;
  logic                         in_valid  = 1'b0;
  logic                         in_stall;
  logic [shp_pkg::PIX_W-1:0]    in_sample = '0;
  logic                         in_flush  = 1'b0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [shp_pkg::PIX_W-1:0]    out_sharpened;
  logic                         out_frame_end;

  sharpen_scoreboard book = new();
  int unsigned       fed          = 0;
  int unsigned       hold_left    = 0;
  int unsigned       quiet        = 0;
  bit                hold_pending = 1'b0;
  bit                calm         = 1'b0;

  sharpen_3x3_laplacian_filter_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_sample     (in_sample),
    .in_flush      (in_flush),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sharpened (out_sharpened),
    .out_frame_end (out_frame_end)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit idle_roll();
    return !calm && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= idle_roll();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      book.check_pixel(out_sharpened, out_frame_end);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(input shp_pkg::reg_idx_t idx,
                           input logic [shp_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // returns at the rising edge of the transfer; valid is left high
  task automatic push_sample(input logic [shp_pkg::PIX_W-1:0] s, input logic f);
    @(negedge clk);
    while (idle_roll()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    in_flush  <= f;
    do @(posedge clk); while (in_stall);
    book.take_sample(s, f);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned ch);
    wait_drained();
    write_reg(shp_pkg::REG_IMAGE_WIDTH, w);
    write_reg(shp_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(shp_pkg::REG_CHANNEL_COUNT, ch);
  endtask

  // one frame plus its flush row; noisy frames flip the flush flag now and then
  task automatic drive_frame(input bit noisy);
    int unsigned               w, h, ch;
    logic [shp_pkg::PIX_W-1:0] s;
    logic                      f;
    w  = effective(book.img_w, LINE_MAX);
    h  = effective(book.img_h, shp_pkg::MAX_HEIGHT);
    ch = effective(book.chans, CHAN_MAX);
    for (int unsigned r = 0; r <= h; r++) begin
      for (int unsigned k = 0; k < w * ch; k++) begin
        calm = (fed >= CALM_FROM && fed < CALM_TO);
        if ($urandom_range(0, 9) < 3) s = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else s = $urandom_range(0, 255);
        f = (r == h);
        if (noisy && $urandom_range(0, 19) == 0) f = !f;
        push_sample(s, f);
        fed++;
      end
    end
  endtask

  initial begin
    int unsigned w, h, ch;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed frame: clamp high and low, flush inside the image and a live flush row
    set_geometry(4, 3, 1);
    for (int k = 0; k < 16; k++)
      push_sample(DIR_PIX[shp_pkg::PIX_W*(15-k) +: shp_pkg::PIX_W], DIR_FLUSH[15-k]);

    fed = 0;
    while (fed < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        if ($urandom_range(0, 9) == 0) w = $urandom_range(0, 1) ? $urandom_range(11, 48) : 0;
        else w = $urandom_range(1, 10);
        if ($urandom_range(0, 9) == 0) h = $urandom_range(0, 1) ? $urandom_range(6, 9) : 0;
        else h = $urandom_range(1, 5);
        if ($urandom_range(0, 9) == 0) ch = $urandom_range(0, 1) ? $urandom_range(5, 7) : 0;
        else ch = $urandom_range(1, 4);
        set_geometry(w, h, ch);
      end
      drive_frame(1'b1);
    end

    // register extremes: all zeros, then a channel count above the limit
    // driven into a long result hold-off
    set_geometry(0, 0, 0);
    drive_frame(1'b0);
    set_geometry(20, 3, 7);
    hold_pending = 1'b1;
    drive_frame(1'b0);

    wait_drained();
    if (book.failures == 0 && book.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
